@@ design/ihr_pkg.sv @@
`timescale 1ns / 1ps

package ihr_pkg;

  localparam int DefSlots = 4;
  localparam int DefDepth = 64;

  localparam int TickW = 32;
  localparam int CntW  = 32;
  localparam int CmdW  = 3;
  localparam int SlotW = 2;
  localparam int ActW  = 3;

  localparam logic [CmdW-1:0] CmdPut      = 3'd0;
  localparam logic [CmdW-1:0] CmdGet      = 3'd1;
  localparam logic [CmdW-1:0] CmdHoldLast = 3'd2;
  localparam logic [CmdW-1:0] CmdIdle     = 3'd3;
  localparam logic [CmdW-1:0] CmdPromote  = 3'd4;

  localparam logic [15:0] IdleButtons = 16'hFFFF;

  typedef struct packed {
    logic        predicted;
    logic        analog;
    logic [7:0]  stick_y;
    logic [7:0]  stick_x;
    logic [15:0] buttons;
  } frame_t;

  typedef struct packed {
    logic             valid;
    logic [TickW-1:0] tick;
    frame_t           frame;
  } entry_t;

  localparam frame_t IdleFrame = '{
    predicted: 1'b1,
    analog:    1'b0,
    stick_y:   8'd0,
    stick_x:   8'd0,
    buttons:   IdleButtons
  };

endpackage

@@ design/ihr_ram.sv @@
`timescale 1ns / 1ps

module ihr_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ihr_mod.sv @@
`timescale 1ns / 1ps

// tick modulo Depth: a mask for a power of two, else a reciprocal multiply
// whose low quotient bits are registered before the remainder is formed
module ihr_mod #(
  parameter int Depth = ihr_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ihr_pkg::TickW-1:0]     tick_i,
  output logic                          done_o,
  output logic [$clog2(Depth)-1:0]      rem_o
);

  localparam int  IdxW   = $clog2(Depth);
  localparam bit  IsPow2 = (Depth == (1 << IdxW));
  localparam int  TickW  = ihr_pkg::TickW;

  if (IsPow2) begin : g_mask
    logic            done_q;
    logic [IdxW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= tick_i[IdxW-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // rounded-up reciprocal gives the exact quotient for every 32-bit tick;
    // only the low quotient bits matter for the remainder
    localparam int             ShW   = TickW + IdxW;
    localparam logic [TickW:0] Recip = (TickW+1)'(((64'd1 << ShW) / 64'(Depth)) + 64'd1);

    logic              stage_q;
    logic              done_q;
    logic [IdxW-1:0]   qlo_q;
    logic [IdxW-1:0]   nlo_q;
    logic [IdxW-1:0]   rem_q;
    logic [2*TickW:0]  prod;
    logic [IdxW-1:0]   qd;

    assign prod = (2*TickW+1)'(tick_i) * (2*TickW+1)'(Recip);
    assign qd   = IdxW'(qlo_q * IdxW'(Depth));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= start_i;
        done_q  <= stage_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        qlo_q <= prod[ShW +: IdxW];
        nlo_q <= tick_i[IdxW-1:0];
      end
      if (stage_q) begin
        rem_q <= nlo_q - qd;
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

@@ design/input_history_ring_core.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// in        in   in_valid_i / in_stall_o  cmd, slot, tick, frame, frame_valid
// out       out  out_valid_o / out_stall_i ok, tick, frame fields, both counters
// cfg       in   cfg_valid_i / cfg_ready_o cfg_data_i (active_slots)
//
// One transaction at a time. Put, promote and idle invent pass through MOD
// (tick modulo: a mask for a power-of-two DEPTH, else a registered reciprocal
// multiply), EXEC and DONE before the next acceptance; get adds a RAM read
// state; hold-last repeats PROBE once per RAM probe, up to DEPTH-1 probes.
// After reset a clearing pass writes all SLOTS*DEPTH entries, one per cycle,
// with input stalled; config writes are taken throughout.
// While the output register is stalled the finished result waits in DONE; no new
// input is taken until that result has moved into the output register.
module input_history_ring_core #(
  parameter int SLOTS = ihr_pkg::DefSlots,
  parameter int DEPTH = ihr_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ihr_pkg::CmdW-1:0]    cmd_i,
  input  logic [ihr_pkg::SlotW-1:0]   slot_i,
  input  logic [ihr_pkg::TickW-1:0]   tick_i,
  input  logic [15:0]                 buttons_i,
  input  logic signed [7:0]           stick_x_i,
  input  logic signed [7:0]           stick_y_i,
  input  logic                        analog_i,
  input  logic                        predicted_i,
  input  logic                        frame_valid_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [ihr_pkg::TickW-1:0]   out_tick_o,
  output logic [15:0]                 out_buttons_o,
  output logic signed [7:0]           out_stick_x_o,
  output logic signed [7:0]           out_stick_y_o,
  output logic                        out_analog_o,
  output logic                        out_predicted_o,
  output logic [ihr_pkg::CntW-1:0]    invents_total_o,
  output logic [ihr_pkg::CntW-1:0]    promotes_total_o,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ihr_pkg::ActW-1:0]    cfg_data_i
);

  localparam int IdxW    = $clog2(DEPTH);
  localparam int Entries = SLOTS * DEPTH;
  localparam int AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int TickW   = ihr_pkg::TickW;
  localparam int CntW    = ihr_pkg::CntW;
  localparam int ActW    = ihr_pkg::ActW;
  localparam int SlotW   = ihr_pkg::SlotW;
  localparam int CmdW    = ihr_pkg::CmdW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_EXEC,
    S_GET,
    S_PROBE,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [AddrW-1:0]    clr_q;
  logic [ActW-1:0]     act_q;
  logic [CntW-1:0]     inv_q;
  logic [CntW-1:0]     prom_q;

  logic [CmdW-1:0]     cmd_q;
  logic [SlotW-1:0]    slot_q;
  logic [TickW-1:0]    tick_q;
  ihr_pkg::frame_t     fin_q;
  logic                fv_q;
  logic [IdxW-1:0]     idx_q;
  logic [IdxW-1:0]     pidx_q;
  logic [IdxW-1:0]     look_q;
  logic [TickW-1:0]    probe_q;
  logic                ok_q;
  logic                show_q;
  ihr_pkg::frame_t     res_q;

  logic                out_valid_q;
  logic                out_ok_q;
  logic [TickW-1:0]    out_tick_q;
  ihr_pkg::frame_t     out_frame_q;
  logic [CntW-1:0]     out_inv_q;
  logic [CntW-1:0]     out_prom_q;

  logic                mod_done;
  logic [IdxW-1:0]     mod_rem;

  logic                ram_we;
  logic                ram_re;
  logic [AddrW-1:0]    ram_waddr;
  logic [AddrW-1:0]    ram_raddr;
  ihr_pkg::entry_t     ram_wdata;
  ihr_pkg::entry_t     ram_rdata;

  logic                in_acc;
  logic                slot_ok;
  logic                get_hit;
  logic                probe_hit;
  logic                probe_end;
  logic [IdxW-1:0]     pidx_first;
  logic [IdxW-1:0]     pidx_next;
  logic                out_free;
  ihr_pkg::frame_t     hold_frame;
  ihr_pkg::frame_t     fin_d;
  logic [ActW-1:0]     act_d;

  function automatic logic [AddrW-1:0] cell_addr(input logic [SlotW-1:0] s,
                                                 input logic [IdxW-1:0]  i);
    logic [AddrW-1:0] base;
    base = AddrW'(AddrW'(s) * AddrW'(DEPTH));
    return base + AddrW'(i);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign slot_ok    = {1'b0, slot_q} < act_q;
  assign get_hit    = ram_rdata.valid && (ram_rdata.tick == tick_q);
  assign probe_hit  = ram_rdata.valid && (ram_rdata.tick == probe_q);
  assign probe_end  = (look_q == IdxW'(DEPTH - 1)) || (probe_q == '0);
  assign pidx_first = idx_dec(idx_q);
  assign pidx_next  = idx_dec(pidx_q);

  always_comb begin
    hold_frame           = ram_rdata.frame;
    hold_frame.predicted = 1'b1;
  end

  always_comb begin
    fin_d.buttons   = buttons_i;
    fin_d.stick_x   = stick_x_i;
    fin_d.stick_y   = stick_y_i;
    fin_d.analog    = analog_i;
    fin_d.predicted = (cmd_i == ihr_pkg::CmdPut) ? predicted_i : 1'b0;
  end

  // clamp register writes to 1..SLOTS
  always_comb begin
    act_d = cfg_data_i;
    if (cfg_data_i == '0) begin
      act_d = ActW'(1);
    end else if (int'(cfg_data_i) > SLOTS) begin
      act_d = ActW'(SLOTS);
    end
  end

  ihr_mod #(
    .Depth (DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .tick_i  (tick_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cell_addr(slot_q, idx_q);
    ram_raddr = cell_addr(slot_q, idx_q);
    ram_wdata = '{valid: 1'b1, tick: tick_q, frame: ihr_pkg::IdleFrame};
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_EXEC: begin
        unique case (cmd_q)
          ihr_pkg::CmdPut, ihr_pkg::CmdPromote: begin
            ram_we          = fv_q && slot_ok;
            ram_wdata.frame = fin_q;
          end
          ihr_pkg::CmdGet: begin
            ram_re = slot_ok;
          end
          ihr_pkg::CmdIdle: begin
            ram_we = slot_ok;
          end
          ihr_pkg::CmdHoldLast: begin
            if (slot_ok) begin
              if (tick_q == '0) begin
                ram_we = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cell_addr(slot_q, pidx_first);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_PROBE: begin
        if (probe_hit) begin
          ram_we          = 1'b1;
          ram_wdata.frame = hold_frame;
        end else if (probe_end) begin
          ram_we = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cell_addr(slot_q, pidx_next);
        end
      end
      default: begin
      end
    endcase
  end

  ihr_ram #(
    .Width ($bits(ihr_pkg::entry_t)),
    .Depth (Entries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      act_q       <= ActW'(1);
      inv_q       <= '0;
      prom_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        act_q <= act_d;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(Entries - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q <= ihr_pkg::IdleFrame;
          unique case (cmd_q)
            ihr_pkg::CmdPut, ihr_pkg::CmdPromote: begin
              state_q <= S_DONE;
              ok_q    <= fv_q && slot_ok;
              show_q  <= 1'b0;
              if (fv_q && slot_ok && cmd_q == ihr_pkg::CmdPromote) begin
                prom_q <= prom_q + 1'b1;
              end
            end
            ihr_pkg::CmdGet: begin
              state_q <= slot_ok ? S_GET : S_DONE;
              ok_q    <= 1'b0;
              show_q  <= 1'b0;
            end
            ihr_pkg::CmdIdle: begin
              state_q <= S_DONE;
              ok_q    <= slot_ok;
              show_q  <= slot_ok;
              if (slot_ok) begin
                inv_q <= inv_q + 1'b1;
              end
            end
            ihr_pkg::CmdHoldLast: begin
              // tick zero has nothing earlier to copy
              state_q <= (slot_ok && tick_q != '0) ? S_PROBE : S_DONE;
              ok_q    <= slot_ok;
              show_q  <= slot_ok;
              probe_q <= tick_q - 1'b1;
              look_q  <= IdxW'(1);
              pidx_q  <= pidx_first;
              if (slot_ok && tick_q == '0) begin
                inv_q <= inv_q + 1'b1;
              end
            end
            default: begin
              state_q <= S_DONE;
              ok_q    <= 1'b0;
              show_q  <= 1'b0;
            end
          endcase
        end
        S_GET: begin
          ok_q    <= get_hit;
          show_q  <= get_hit;
          res_q   <= ram_rdata.frame;
          state_q <= S_DONE;
        end
        S_PROBE: begin
          if (probe_hit || probe_end) begin
            ok_q    <= 1'b1;
            show_q  <= 1'b1;
            inv_q   <= inv_q + 1'b1;
            res_q   <= probe_hit ? hold_frame : ihr_pkg::IdleFrame;
            state_q <= S_DONE;
          end else begin
            probe_q <= probe_q - 1'b1;
            look_q  <= look_q + 1'b1;
            pidx_q  <= pidx_next;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // transaction and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      tick_q <= tick_i;
      fin_q  <= fin_d;
      fv_q   <= frame_valid_i;
    end
    if (state_q == S_MOD && mod_done) begin
      idx_q <= mod_rem;
    end
    if (state_q == S_DONE && out_free) begin
      out_ok_q    <= ok_q;
      out_tick_q  <= show_q ? tick_q : '0;
      out_frame_q <= show_q ? res_q : '0;
      out_inv_q   <= inv_q;
      out_prom_q  <= prom_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_ok_q;
  assign out_tick_o       = out_tick_q;
  assign out_buttons_o    = out_frame_q.buttons;
  assign out_stick_x_o    = out_frame_q.stick_x;
  assign out_stick_y_o    = out_frame_q.stick_y;
  assign out_analog_o     = out_frame_q.analog;
  assign out_predicted_o  = out_frame_q.predicted;
  assign invents_total_o  = out_inv_q;
  assign promotes_total_o = out_prom_q;

  // single-port style use: never read and write in the same cycle
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  a_write_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLEAR) |-> ram_wdata.valid)
    else $error("functional write without valid mark");

  a_probe_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (look_q != '0 && cmd_q == ihr_pkg::CmdHoldLast))
    else $error("probe outside hold-last or past history depth");

  a_inv_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inv_q != $past(inv_q)) |-> (inv_q == $past(inv_q) + 1'b1 && prom_q == $past(prom_q)))
    else $error("invent counter moved by more than one or with promote");

  a_prom_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prom_q != $past(prom_q)) |-> ($past(cmd_q) == ihr_pkg::CmdPromote))
    else $error("promote counter moved on another command");

endmodule

@@ bench/ihr_ring_checker.sv @@
`timescale 1ns / 1ps

module ihr_ring_checker #(
  parameter int SLOTS = ihr_pkg::DefSlots,
  parameter int DEPTH = ihr_pkg::DefDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [ihr_pkg::CmdW-1:0]  cmd_i,
  input  logic [ihr_pkg::SlotW-1:0] slot_i,
  input  logic [ihr_pkg::TickW-1:0] tick_i,
  input  logic [15:0]               buttons_i,
  input  logic [7:0]                stick_x_i,
  input  logic [7:0]                stick_y_i,
  input  logic                      analog_i,
  input  logic                      predicted_i,
  input  logic                      frame_valid_i,

  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic                      ok_i,
  input  logic [ihr_pkg::TickW-1:0] out_tick_i,
  input  logic [15:0]               out_buttons_i,
  input  logic [7:0]                out_stick_x_i,
  input  logic [7:0]                out_stick_y_i,
  input  logic                      out_analog_i,
  input  logic                      out_predicted_i,
  input  logic [ihr_pkg::CntW-1:0]  invents_total_i,
  input  logic [ihr_pkg::CntW-1:0]  promotes_total_i,

  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [ihr_pkg::ActW-1:0]  cfg_data_i,

  output int                        mismatches_o,
  output int                        outstanding_o,
  output int                        checked_o
);

  import ihr_pkg::*;

  typedef struct packed {
    logic            ok;
    logic [TickW-1:0] tick;
    frame_t          frame;
    logic [CntW-1:0] invents;
    logic [CntW-1:0] promotes;
  } ring_outcome_t;

  // shadow copy of the history ring
  logic [TickW-1:0] hist_tick [SLOTS*DEPTH];
  frame_t           hist_frame [SLOTS*DEPTH];
  logic             hist_valid [SLOTS*DEPTH];
  logic [CntW-1:0]  invent_cnt;
  logic [CntW-1:0]  promote_cnt;
  int               slots_in_use;

  ring_outcome_t    expected_outcomes [$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
  end

  function automatic int entry_index(input logic [SlotW-1:0] sl, input logic [TickW-1:0] tk);
    return int'(sl) * DEPTH + int'(tk % DEPTH);
  endfunction

  function automatic void write_entry(input logic [SlotW-1:0] sl, input logic [TickW-1:0] tk,
                                      input frame_t fr);
    int idx;
    idx = entry_index(sl, tk);
    hist_tick[idx]  = tk;
    hist_frame[idx] = fr;
    hist_valid[idx] = 1'b1;
  endfunction

  function automatic ring_outcome_t apply_history_cmd(
    input logic [CmdW-1:0]  op,
    input logic [SlotW-1:0] sl,
    input logic [TickW-1:0] tk,
    input frame_t           fr,
    input logic             fv
  );
    ring_outcome_t    res;
    frame_t           hold;
    logic [TickW-1:0] back;
    logic             slot_ok;
    logic             found;
    int               idx;
    int               look;
    res     = '0;
    slot_ok = int'(sl) < slots_in_use;
    case (op)
      CmdPut, CmdPromote: begin
        if (fv && slot_ok) begin
          hold = fr;
          if (op == CmdPromote) begin
            hold.predicted = 1'b0;
            promote_cnt++;
          end
          write_entry(sl, tk, hold);
          res.ok = 1'b1;
        end
      end
      CmdGet: begin
        idx = entry_index(sl, tk);
        if (slot_ok && hist_valid[idx] && hist_tick[idx] == tk) begin
          res.ok    = 1'b1;
          res.tick  = tk;
          res.frame = hist_frame[idx];
        end
      end
      CmdHoldLast, CmdIdle: begin
        if (slot_ok) begin
          hold  = '{predicted: 1'b1, analog: 1'b0, stick_y: 8'd0, stick_x: 8'd0,
                    buttons: IdleButtons};
          found = 1'b0;
          // nearest earlier tick wins; never looks below tick zero
          if (op == CmdHoldLast) begin
            for (look = 1; look < DEPTH && !found && tk >= look; look++) begin
              back = tk - TickW'(look);
              idx  = entry_index(sl, back);
              if (hist_valid[idx] && hist_tick[idx] == back) begin
                found          = 1'b1;
                hold           = hist_frame[idx];
                hold.predicted = 1'b1;
              end
            end
          end
          write_entry(sl, tk, hold);
          invent_cnt++;
          res.ok    = 1'b1;
          res.tick  = tk;
          res.frame = hold;
        end
      end
      default: ;
    endcase
    res.invents  = invent_cnt;
    res.promotes = promote_cnt;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (mismatches_o < 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ring_outcome_t want;
    frame_t        fr;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS * DEPTH; i++) begin
        hist_valid[i] = 1'b0;
        hist_tick[i]  = '0;
        hist_frame[i] = '0;
      end
      invent_cnt   = '0;
      promote_cnt  = '0;
      slots_in_use = 1;
      expected_outcomes.delete();
      outstanding_o = 0;
    end else begin
      // a result can never belong to a command taken on the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_outcomes.size() == 0) begin
          if (mismatches_o < 10)
            $display("[%0t] result with no command outstanding", $realtime);
          mismatches_o++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("ok", 32'(want.ok), 32'(ok_i));
          check_field("out_tick", want.tick, out_tick_i);
          check_field("out_buttons", 32'(want.frame.buttons), 32'(out_buttons_i));
          check_field("out_stick_x", 32'(want.frame.stick_x), 32'(out_stick_x_i));
          check_field("out_stick_y", 32'(want.frame.stick_y), 32'(out_stick_y_i));
          check_field("out_analog", 32'(want.frame.analog), 32'(out_analog_i));
          check_field("out_predicted", 32'(want.frame.predicted), 32'(out_predicted_i));
          check_field("invents_total", want.invents, invents_total_i);
          check_field("promotes_total", want.promotes, promotes_total_i);
          checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (int'(cfg_data_i) < 1)
          slots_in_use = 1;
        else if (int'(cfg_data_i) > SLOTS)
          slots_in_use = SLOTS;
        else
          slots_in_use = int'(cfg_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        fr = '{predicted: predicted_i, analog: analog_i, stick_y: stick_y_i,
               stick_x: stick_x_i, buttons: buttons_i};
        expected_outcomes.push_back(apply_history_cmd(cmd_i, slot_i, tick_i, fr,
                                                      frame_valid_i));
      end
      outstanding_o = expected_outcomes.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  import ihr_pkg::*;

  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 100;
  localparam int LongHold    = 400;
  localparam int PhaseItems  = 200;

  localparam logic [CmdW-1:0] CmdUnknownLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnknownMid = 3'd6;
  localparam logic [CmdW-1:0] CmdUnknownHi = 3'd7;

  // active_slots per random phase, element 0 first; 0 and 7 exercise the clamp
  localparam logic [5:0][ActW-1:0] PhaseSlots = {3'd3, 3'd0, 3'd2, 3'd7, 3'd1, 3'd4};

  logic clk_i;
  logic rst_n = 1'b0;

  logic             in_valid    = 1'b0;
  logic [CmdW-1:0]  cmd         = CmdPut;
  logic [SlotW-1:0] slot        = '0;
  logic [TickW-1:0] tick        = '0;
  logic [15:0]      buttons     = '0;
  logic [7:0]       stick_x     = '0;
  logic [7:0]       stick_y     = '0;
  logic             analog      = 1'b0;
  logic             predicted   = 1'b0;
  logic             frame_valid = 1'b0;
  logic             out_stall   = 1'b0;
  logic             cfg_valid   = 1'b0;
  logic [ActW-1:0]  cfg_data    = '0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic             ok_o;
  logic [TickW-1:0] out_tick_o;
  logic [15:0]      out_buttons_o;
  logic [7:0]       out_stick_x_o;
  logic [7:0]       out_stick_y_o;
  logic             out_analog_o;
  logic             out_predicted_o;
  logic [CntW-1:0]  invents_total_o;
  logic [CntW-1:0]  promotes_total_o;
  logic             cfg_ready_o;

  int mismatches;
  int outstanding;
  int checked;

  int tx_idle_pct = 30;
  int rx_idle_pct = 70;
  int slots_now = 1;
  int items_sent = 0;
  int slot_writes = 0;
  logic long_hold_req = 1'b0;
  logic [TickW-1:0] tick_cursor [DefSlots];

  wire moved = (in_valid & ~in_stall_o) | (out_valid_o & ~out_stall) |
               (cfg_valid & cfg_ready_o);

  input_history_ring_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd),
    .slot_i           (slot),
    .tick_i           (tick),
    .buttons_i        (buttons),
    .stick_x_i        (stick_x),
    .stick_y_i        (stick_y),
    .analog_i         (analog),
    .predicted_i      (predicted),
    .frame_valid_i    (frame_valid),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .ok_o             (ok_o),
    .out_tick_o       (out_tick_o),
    .out_buttons_o    (out_buttons_o),
    .out_stick_x_o    (out_stick_x_o),
    .out_stick_y_o    (out_stick_y_o),
    .out_analog_o     (out_analog_o),
    .out_predicted_o  (out_predicted_o),
    .invents_total_o  (invents_total_o),
    .promotes_total_o (promotes_total_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data)
  );

  ihr_ring_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd),
    .slot_i           (slot),
    .tick_i           (tick),
    .buttons_i        (buttons),
    .stick_x_i        (stick_x),
    .stick_y_i        (stick_y),
    .analog_i         (analog),
    .predicted_i      (predicted),
    .frame_valid_i    (frame_valid),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall),
    .ok_i             (ok_o),
    .out_tick_i       (out_tick_o),
    .out_buttons_i    (out_buttons_o),
    .out_stick_x_i    (out_stick_x_o),
    .out_stick_y_i    (out_stick_y_o),
    .out_analog_i     (out_analog_o),
    .out_predicted_i  (out_predicted_o),
    .invents_total_i  (invents_total_o),
    .promotes_total_i (promotes_total_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .outstanding_o    (outstanding),
    .checked_o        (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // output side: random stalls, plus one long hold-off so the block backs up
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (moved)
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", QuietLimit);
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back commands need no gap
  task automatic send_cmd(
    input logic [CmdW-1:0]  op,
    input logic [SlotW-1:0] sl,
    input logic [TickW-1:0] tk,
    input logic [15:0]      btn,
    input logic [7:0]       sx,
    input logic [7:0]       sy,
    input logic             an,
    input logic             pr,
    input logic             fv
  );
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd         <= op;
    slot        <= sl;
    tick        <= tk;
    buttons     <= btn;
    stick_x     <= sx;
    stick_y     <= sy;
    analog      <= an;
    predicted   <= pr;
    frame_valid <= fv;
    in_valid    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic set_slots(input logic [ActW-1:0] val);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (int'(val) < 1)
      slots_now = 1;
    else if (int'(val) > DefSlots)
      slots_now = DefSlots;
    else
      slots_now = int'(val);
    slot_writes++;
  endtask

  task automatic directed_checks();
    // reset value allows slot 0 only
    send_cmd(CmdPut, 2'd1, 32'd5, 16'h1111, 8'h11, 8'h22, 1'b1, 1'b0, 1'b1);
    send_cmd(CmdGet, 2'd1, 32'd5, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdPut, 2'd0, 32'd0, 16'hFFFF, 8'h80, 8'h7F, 1'b1, 1'b1, 1'b1);
    send_cmd(CmdGet, 2'd0, 32'd0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdHoldLast, 2'd0, 32'd0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    set_slots(3'd4);
    // same ring entry, different tick
    send_cmd(CmdGet, 2'd0, 32'd64, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdPut, 2'd3, 32'hFFFF_FFFF, 16'h0000, 8'h7F, 8'h80, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdGet, 2'd3, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdPut, 2'd2, 32'd10, 16'hBEEF, 8'h01, 8'h02, 1'b1, 1'b1, 1'b0);
    send_cmd(CmdGet, 2'd2, 32'd10, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdPromote, 2'd2, 32'd10, 16'h1234, 8'h05, 8'hFB, 1'b1, 1'b1, 1'b1);
    send_cmd(CmdGet, 2'd2, 32'd10, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdPromote, 2'd2, 32'd11, 16'h4321, 8'h09, 8'h09, 1'b0, 1'b0, 1'b0);
    send_cmd(CmdHoldLast, 2'd2, 32'd12, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    // lookback window edge: 37 is 64 below 101 and 63 below 100
    send_cmd(CmdPut, 2'd1, 32'd37, 16'hA5A5, 8'hC3, 8'h3C, 1'b1, 1'b0, 1'b1);
    send_cmd(CmdHoldLast, 2'd1, 32'd101, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdHoldLast, 2'd1, 32'd100, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdIdle, 2'd3, 32'd3, 16'h5555, 8'h55, 8'h55, 1'b1, 1'b0, 1'b1);
    send_cmd(CmdGet, 2'd3, 32'd3, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    send_cmd(CmdUnknownLo, 2'd0, 32'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_cmd(CmdUnknownMid, 2'd0, 32'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
    send_cmd(CmdUnknownHi, 2'd0, 32'd0, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic random_item();
    logic [CmdW-1:0]  op;
    logic [SlotW-1:0] sl;
    logic [TickW-1:0] tk;
    int               pick;
    int               step;
    pick = $urandom_range(99);
    if (pick < 30)
      op = CmdPut;
    else if (pick < 55)
      op = CmdGet;
    else if (pick < 70)
      op = CmdHoldLast;
    else if (pick < 78)
      op = CmdIdle;
    else if (pick < 93)
      op = CmdPromote;
    else
      op = CmdPromote + CmdW'($urandom_range(1, 3));
    if ($urandom_range(99) < 85)
      sl = SlotW'($urandom_range(slots_now - 1));
    else
      sl = SlotW'($urandom);
    if ($urandom_range(99) < 4) begin
      case ($urandom_range(3))
        0: tick_cursor[sl] = '0;
        1: tick_cursor[sl] = $urandom;
        2: tick_cursor[sl] = 32'hFFFF_FFC0 + TickW'($urandom_range(63));
        default: tick_cursor[sl] = TickW'($urandom_range(200));
      endcase
    end
    if (op == CmdGet) begin
      tk = tick_cursor[sl] - TickW'($urandom_range(70));
    end else begin
      pick = $urandom_range(99);
      if (pick < 70)
        step = 1;
      else if (pick < 90)
        step = $urandom_range(2, 8);
      else
        step = $urandom_range(40, 90);
      tick_cursor[sl] = tick_cursor[sl] + TickW'(step);
      tk = tick_cursor[sl];
    end
    if ($urandom_range(99) < 5)
      tk = $urandom;
    send_cmd(op, sl, tk, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
             1'($urandom), $urandom_range(99) < 90);
  endtask

  initial begin : stimulus
    int ph;
    for (int i = 0; i < DefSlots; i++)
      tick_cursor[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    directed_checks();
    for (ph = 0; ph < 6; ph++) begin
      set_slots(PhaseSlots[ph]);
      case (ph / 2)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 4)
        long_hold_req = 1'b1;
      repeat (PhaseItems) random_item();
    end
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d commands, %0d results checked, %0d active_slots writes,",
             items_sent, checked, slot_writes);
    $display("three idle patterns and one long output hold-off.");
    if (mismatches == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
design/ihr_pkg.sv
design/ihr_ram.sv
design/ihr_mod.sv
design/input_history_ring_core.sv
bench/ihr_ring_checker.sv
bench/tb_top.sv
